>>> sv/ttb_pkg.sv
// Package for the triangle tangent/bitangent block: widths, beat types and
// the command and status structs between controller and datapath.
// No dependencies.
package ttb_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int OUT_FRAC_BITS = 14;

    localparam int DW    = COORD_WIDTH + 1;
    localparam int MUL_W = (DW > 31) ? DW : 31;
    localparam int VW    = 2 * DW + 1;
    localparam int SW    = 62;
    localparam int QW    = OUT_FRAC_BITS + 1;
    localparam int RW    = 31 + OUT_FRAC_BITS;

    localparam int SEL_W      = 5;
    localparam int N_PROD     = 14;
    localparam int SQ_SEL0    = 14;
    localparam int SQRT_STEPS = SW / 2;
    localparam int CNT_W      = 6;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic               mesh_start;
    } t_corner;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] bitangent_x;
        logic signed [15:0] bitangent_y;
        logic signed [15:0] bitangent_z;
        logic               degenerate;
    } t_result;

    typedef struct packed {
        logic             load_c1;
        logic             load_c2;
        logic             load_c3;
        logic             mul_en;
        logic [SEL_W-1:0] mul_sel;
        logic             norm_load;
        logic             norm_step;
        logic             sqrt_init;
        logic             sqrt_step;
        logic             div_init;
        logic             div_step;
        logic             div_store;
        logic             out_load;
        logic             vec;
        logic [1:0]       comp;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic norm_done;
        logic out_free;
    } t_status;

endpackage

>>> sv/ttb_ctrl.sv
// Sequencer for the triangle tangent/bitangent block.
// Depends on ttb_pkg; drives ttb_datapath through t_cmd and reads t_status.
module ttb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_mesh_start,
    output logic            o_in_ready,
    input  ttb_pkg::t_status i_status,
    output ttb_pkg::t_cmd   o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL   = 10'b0000000010,
        S_DRAIN = 10'b0000000100,
        S_NLOAD = 10'b0000001000,
        S_NORM  = 10'b0000010000,
        S_SQ    = 10'b0000100000,
        S_SQD   = 10'b0001000000,
        S_SQRT  = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state                   r_state, n_state;
    logic [ttb_pkg::CNT_W-1:0] r_k, n_k;
    logic [1:0]               r_cc, n_cc;
    logic                     r_vec, n_vec;
    logic [1:0]               r_comp, n_comp;
    logic [1:0]               w_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_cc    <= '0;
            r_vec   <= 1'b0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_cc    <= n_cc;
            r_vec   <= n_vec;
            r_comp  <= n_comp;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_cc       = r_cc;
        n_vec      = r_vec;
        n_comp     = r_comp;
        o_cmd      = '0;
        o_cmd.vec  = r_vec;
        o_cmd.comp = r_comp;
        o_in_ready = 1'b0;
        w_cnt      = i_mesh_start ? 2'd0 : r_cc;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (w_cnt)
                        2'd1: begin
                            o_cmd.load_c2 = 1'b1;
                            n_cc = 2'd2;
                        end
                        2'd2: begin
                            o_cmd.load_c3 = 1'b1;
                            n_cc    = 2'd0;
                            n_k     = '0;
                            n_state = S_MUL;
                        end
                        default: begin
                            o_cmd.load_c1 = 1'b1;
                            n_cc = 2'd1;
                        end
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = r_k[ttb_pkg::SEL_W-1:0];
                if (r_k == ttb_pkg::CNT_W'(ttb_pkg::N_PROD - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                n_vec   = 1'b0;
                n_state = S_NLOAD;
            end
            S_NLOAD: begin
                o_cmd.norm_load = 1'b1;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (i_status.zero) begin
                    if (!r_vec) begin
                        n_vec   = 1'b1;
                        n_state = S_NLOAD;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (i_status.norm_done) begin
                    n_k     = '0;
                    n_state = S_SQ;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            S_SQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = ttb_pkg::SEL_W'(ttb_pkg::SQ_SEL0) + r_k[ttb_pkg::SEL_W-1:0];
                if (r_k == ttb_pkg::CNT_W'(2)) begin
                    n_state = S_SQD;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_SQD: begin
                n_k     = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_k == '0) begin
                    o_cmd.sqrt_init = 1'b1;
                end else begin
                    o_cmd.sqrt_step = 1'b1;
                end
                if (r_k == ttb_pkg::CNT_W'(ttb_pkg::SQRT_STEPS)) begin
                    n_k     = '0;
                    n_comp  = '0;
                    n_state = S_DIV;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DIV: begin
                n_k = r_k + 1'b1;
                if (r_k == '0) begin
                    o_cmd.div_init = 1'b1;
                end else if (r_k == ttb_pkg::CNT_W'(ttb_pkg::QW + 1)) begin
                    o_cmd.div_store = 1'b1;
                    n_k = '0;
                    if (r_comp == 2'd2) begin
                        if (!r_vec) begin
                            n_vec   = 1'b1;
                            n_state = S_NLOAD;
                        end else begin
                            n_state = S_OUT;
                        end
                    end else begin
                        n_comp = r_comp + 1'b1;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_cc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cc != 2'd3) else $error("corner count reached three");
    a_norm_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM && !i_status.zero && !i_status.norm_done) |=> r_state == S_NORM)
        else $error("left normalization early");
    a_out_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_status.out_free) |=> (r_state == S_IDLE && r_cc == 2'd0))
        else $error("result not handed off");
`endif

endmodule

>>> sv/ttb_datapath.sv
// Datapath of the triangle tangent/bitangent block: corner buffers, shared
// multiplier, normalizer, square root, divider and output register.
// Depends on ttb_pkg; commanded by ttb_ctrl.
module ttb_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ttb_pkg::t_corner i_in_data,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_data,
    input  ttb_pkg::t_cmd    i_cmd,
    output ttb_pkg::t_status o_status,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ttb_pkg::t_result o_out_data
);

    localparam int CW = ttb_pkg::COORD_WIDTH;
    localparam int DW = ttb_pkg::DW;
    localparam int MW = ttb_pkg::MUL_W;
    localparam int VW = ttb_pkg::VW;
    localparam int SW = ttb_pkg::SW;
    localparam int QW = ttb_pkg::QW;
    localparam int RW = ttb_pkg::RW;
    localparam int F  = ttb_pkg::OUT_FRAC_BITS;

    logic                        r_flip;
    logic signed [CW-1:0]        r_c1 [5];
    logic signed [CW-1:0]        r_c2 [5];
    logic signed [DW-1:0]        r_e1 [3];
    logic signed [DW-1:0]        r_e2 [3];
    logic signed [DW-1:0]        r_du1, r_dv1, r_du2, r_dv2;
    logic signed [CW-1:0]        w_c3 [5];
    logic signed [MW-1:0]        w_a, w_b;
    logic signed [2*MW-1:0]      r_prod;
    logic                        r_pv;
    logic [ttb_pkg::SEL_W-1:0]   r_ps;
    logic signed [VW-1:0]        r_acc;
    logic signed [VW-1:0]        r_vecs [7];
    logic signed [VW-1:0]        w_pext;
    logic [VW-1:0]               r_m [3];
    logic [2:0]                  r_neg;
    logic [1:0]                  r_vz;
    logic [VW-1:0]               w_or;
    logic signed [VW-1:0]        w_v [3];
    logic [SW-1:0]               r_sum, r_sx, r_sres, r_bit;
    logic [SW-1:0]               w_trial;
    logic [RW-1:0]               r_rem, r_dvs;
    logic [QW-1:0]               r_q;
    logic [30:0]                 w_root;
    logic signed [15:0]          r_res [6];
    logic [15:0]                 w_mag;
    logic                        w_sat, w_sign, w_dneg;
    logic [2:0]                  w_idx;
    logic                        r_ov;
    ttb_pkg::t_result            r_out;

    assign w_c3[0] = CW'(i_in_data.pos_x);
    assign w_c3[1] = CW'(i_in_data.pos_y);
    assign w_c3[2] = CW'(i_in_data.pos_z);
    assign w_c3[3] = CW'(i_in_data.tex_u);
    assign w_c3[4] = CW'(i_in_data.tex_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip <= 1'b0;
        end else if (i_cfg_valid) begin
            r_flip <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_c1) begin
            for (int i = 0; i < 5; i++) r_c1[i] <= w_c3[i];
        end
        if (i_cmd.load_c2) begin
            for (int i = 0; i < 5; i++) r_c2[i] <= w_c3[i];
        end
        if (i_cmd.load_c3) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= DW'(r_c2[i]) - DW'(r_c1[i]);
                r_e2[i] <= DW'(w_c3[i]) - DW'(r_c1[i]);
            end
            r_du1 <= DW'(r_c2[3]) - DW'(r_c1[3]);
            r_dv1 <= DW'(r_c2[4]) - DW'(r_c1[4]);
            r_du2 <= DW'(w_c3[3]) - DW'(r_c1[3]);
            r_dv2 <= DW'(w_c3[4]) - DW'(r_c1[4]);
        end
    end

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_cmd.mul_sel)
            5'd0:  begin w_a = r_du1; w_b = r_dv2; end
            5'd1:  begin w_a = r_du2; w_b = r_dv1; end
            5'd2:  begin w_a = r_dv2; w_b = r_e1[0]; end
            5'd3:  begin w_a = r_dv1; w_b = r_e2[0]; end
            5'd4:  begin w_a = r_dv2; w_b = r_e1[1]; end
            5'd5:  begin w_a = r_dv1; w_b = r_e2[1]; end
            5'd6:  begin w_a = r_dv2; w_b = r_e1[2]; end
            5'd7:  begin w_a = r_dv1; w_b = r_e2[2]; end
            5'd8:  begin w_a = r_du1; w_b = r_e2[0]; end
            5'd9:  begin w_a = r_du2; w_b = r_e1[0]; end
            5'd10: begin w_a = r_du1; w_b = r_e2[1]; end
            5'd11: begin w_a = r_du2; w_b = r_e1[1]; end
            5'd12: begin w_a = r_du1; w_b = r_e2[2]; end
            5'd13: begin w_a = r_du2; w_b = r_e1[2]; end
            5'd14: begin
                w_a = $signed(MW'(r_m[0][29:0])); w_b = w_a;
            end
            5'd15: begin
                w_a = $signed(MW'(r_m[1][29:0])); w_b = w_a;
            end
            5'd16: begin
                w_a = $signed(MW'(r_m[2][29:0])); w_b = w_a;
            end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_pext = VW'($signed(r_prod[2*DW-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_en;
        end
        r_ps <= i_cmd.mul_sel;
        if (i_cmd.mul_en) begin
            r_prod <= w_a * w_b;
        end
        if (r_pv) begin
            if (r_ps < ttb_pkg::SEL_W'(ttb_pkg::N_PROD)) begin
                if (!r_ps[0]) begin
                    r_acc <= w_pext;
                end else begin
                    r_vecs[r_ps[3:1]] <= r_acc - w_pext;
                end
            end else if (r_ps == ttb_pkg::SEL_W'(ttb_pkg::SQ_SEL0)) begin
                r_sum <= r_prod[SW-1:0];
            end else begin
                r_sum <= r_sum + r_prod[SW-1:0];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i] = i_cmd.vec ? r_vecs[4 + i] : r_vecs[1 + i];
        end
    end

    assign w_or = r_m[0] | r_m[1] | r_m[2];
    assign o_status.zero      = (w_or == '0);
    assign o_status.norm_done = !(|w_or[VW-1:30]) && w_or[29];

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_load) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= w_v[i][VW-1];
                r_m[i]   <= w_v[i][VW-1] ? VW'(-w_v[i]) : VW'(w_v[i]);
            end
            r_vz[i_cmd.vec] <= (w_v[0] == '0) && (w_v[1] == '0) && (w_v[2] == '0);
        end else if (i_cmd.norm_step) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i] <= (|w_or[VW-1:30]) ? (r_m[i] >> 1) : (r_m[i] << 1);
            end
        end
    end

    assign w_trial = r_sres + r_bit;
    assign w_root  = r_sres[30:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_sx   <= r_sum;
            r_sres <= '0;
            r_bit  <= SW'(1) << (SW - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_sx >= w_trial) begin
                r_sx   <= r_sx - w_trial;
                r_sres <= (r_sres >> 1) + r_bit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= (RW'(r_m[i_cmd.comp][29:0]) << F) + RW'(w_root >> 1);
            r_dvs <= RW'(w_root) << F;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_dvs) begin
                r_rem <= r_rem - r_dvs;
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
        end
    end

    assign w_dneg = r_vecs[0][VW-1];
    assign w_sat  = ({16'd0, r_q} > (QW + 16)'(32767));
    assign w_mag  = w_sat ? 16'h7fff : 16'(r_q);
    assign w_sign = r_neg[i_cmd.comp] ^ w_dneg ^ ((i_cmd.comp != 2'd1) ? r_flip : 1'b0);
    assign w_idx  = (i_cmd.vec ? 3'd3 : 3'd0) + {1'b0, i_cmd.comp};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            r_res[w_idx] <= w_sign ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_status.out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if ((r_vecs[0] == '0) || r_vz[0] || r_vz[1]) begin
                r_out.tangent_x   <= '0;
                r_out.tangent_y   <= '0;
                r_out.tangent_z   <= '0;
                r_out.bitangent_x <= '0;
                r_out.bitangent_y <= '0;
                r_out.bitangent_z <= '0;
                r_out.degenerate  <= 1'b1;
            end else begin
                r_out.tangent_x   <= r_res[0];
                r_out.tangent_y   <= r_res[1];
                r_out.tangent_z   <= r_res[2];
                r_out.bitangent_x <= r_res[3];
                r_out.bitangent_y <= r_res[4];
                r_out.bitangent_z <= r_res[5];
                r_out.degenerate  <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

>>> sv/triangle_tangent_bitangent.sv
// Triangle tangent/bitangent unit, top level.
// Depends on ttb_pkg, ttb_ctrl and ttb_datapath.
//
// Usage:
//   Corner beats enter on i_in_valid/o_in_ready/i_in_data; every third
//   corner of a mesh (mesh_start restarts the count) closes a triangle and
//   gives one result beat on o_out_valid/i_out_ready/o_out_data. flip_x_z
//   is written on i_cfg_valid/o_cfg_ready/i_cfg_data; the user must do
//   so only while idle, which the block itself does not enforce.
// Timing:
//   The third corner starts a sequence on one shared multiplier: 14
//   products plus a drain step, then for each vector a one-bit-per-cycle
//   normalizer, three squares, a 31-step square root and three 15-step
//   divisions. The next corner is taken once the result beat is valid; a
//   zero vector skips its square root and divisions.
// Reset: corner grouping restarts, flip_x_z is cleared, no result pending.
// Stall: a finished result waits in the output register; the next triangle
//   corners are taken meanwhile, and a new result waits until it is free.
module triangle_tangent_bitangent (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ttb_pkg::t_corner i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ttb_pkg::t_result o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data
);

    ttb_pkg::t_cmd    w_cmd;
    ttb_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    ttb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_mesh_start (i_in_data.mesh_start),
        .o_in_ready   (o_in_ready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    ttb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
